/* design/hcbp_pkg.sv */
package hcbp_pkg;

  // table geometry
  localparam int MAX_CODE_LEN = 16;
  localparam int SYMBOL_COUNT = 256;
  localparam int SYM_W        = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int CODE_W       = 16;
  localparam int LEN_W        = 5;
  localparam int LEN_LIMIT    = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

  // output queue geometry
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // full byte marker for bits_valid
  localparam logic [3:0] FULL_BYTE = 4'd8;

  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_ENCODE = 2'd1,
    REQ_FLUSH  = 2'd2,
    REQ_RSVD   = 2'd3
  } req_type_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  symbol;
    logic [15:0] code_word;
    logic [4:0]  code_length;
  } in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [3:0]  bits_valid;
    logic        run_end;
    logic        is_final;
    logic [31:0] total_bytes;
  } out_t;

  // up to two results produced by one item
  typedef struct packed {
    logic [1:0] num;
    out_t       res0;
    out_t       res1;
  } res_pair_t;

endpackage

/* design/hcbp_table.sv */
module hcbp_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [hcbp_pkg::SYM_W-1:0]    wr_idx_i,
  input  logic [hcbp_pkg::CODE_W-1:0]   wr_code_i,
  input  logic [hcbp_pkg::LEN_W-1:0]    wr_len_i,
  input  logic                          rd_en_i,
  input  logic [hcbp_pkg::SYM_W-1:0]    rd_idx_i,
  output logic [hcbp_pkg::CODE_W-1:0]   rd_code_o,
  output logic [hcbp_pkg::LEN_W-1:0]    rd_len_o
);
  import hcbp_pkg::*;

  logic [CODE_W-1:0] code_mem [SYMBOL_COUNT];
  logic [LEN_W-1:0]  len_mem  [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] vld_q;

  logic [CODE_W-1:0] code_q;
  logic [LEN_W-1:0]  len_q;
  logic              ent_vld_q;

  // code and length storage, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      code_mem[wr_idx_i] <= wr_code_i;
      len_mem[wr_idx_i]  <= wr_len_i;
    end
    if (rd_en_i) begin
      code_q <= code_mem[rd_idx_i];
      len_q  <= len_mem[rd_idx_i];
    end
  end

  // per-entry written flags, unwritten entries read as length zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      ent_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_idx_i] <= 1'b1;
      end
      if (rd_en_i) begin
        ent_vld_q <= vld_q[rd_idx_i];
      end
    end
  end

  assign rd_code_o = code_q;
  assign rd_len_o  = ent_vld_q ? len_q : '0;

endmodule

/* design/hcbp_packer.sv */
module hcbp_packer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         fire_i,
  input  logic [1:0]                   req_i,
  input  logic [hcbp_pkg::CODE_W-1:0]  code_i,
  input  logic [hcbp_pkg::LEN_W-1:0]   len_i,
  output hcbp_pkg::res_pair_t          res_o
);
  import hcbp_pkg::*;

  logic [6:0]  pend_q, pend_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [31:0] bytes_q, bytes_d;

  logic [16:0] code_mask;
  logic [15:0] bits;
  logic [22:0] acc;
  logic [4:0]  tot;
  logic [4:0]  rem;
  logic [22:0] sh0, sh1;
  logic [7:0]  rem_mask;
  logic        two_bytes, one_byte;
  logic [14:0] flush_sh;

  // merge the code into the pending bits and cut out full bytes
  always_comb begin
    code_mask = (17'd1 << len_i) - 17'd1;
    bits      = code_i & code_mask[15:0];
    acc       = ({16'd0, pend_q} << len_i) | {7'd0, bits};
    tot       = {2'd0, cnt_q} + len_i;
    two_bytes = (tot >= 5'd16);
    one_byte  = (tot >= 5'd8);
    sh0       = acc >> (tot - 5'd8);
    sh1       = acc >> (tot - 5'd16);
    if (two_bytes) begin
      rem = tot - 5'd16;
    end else if (one_byte) begin
      rem = tot - 5'd8;
    end else begin
      rem = tot;
    end
    rem_mask = (8'd1 << rem) - 8'd1;
    flush_sh = {8'd0, pend_q} << (4'd8 - {1'b0, cnt_q});
  end

  // results and next state per request type
  always_comb begin
    res_o   = '0;
    pend_d  = pend_q;
    cnt_d   = cnt_q;
    bytes_d = bytes_q;
    unique case (req_i)
      REQ_ENCODE: begin
        res_o.res0.out_byte   = sh0[7:0];
        res_o.res0.bits_valid = FULL_BYTE;
        res_o.res0.run_end    = !two_bytes;
        res_o.res1.out_byte   = sh1[7:0];
        res_o.res1.bits_valid = FULL_BYTE;
        res_o.res1.run_end    = 1'b1;
        res_o.num = two_bytes ? 2'd2 : (one_byte ? 2'd1 : 2'd0);
        pend_d  = acc[6:0] & rem_mask[6:0];
        cnt_d   = rem[2:0];
        bytes_d = bytes_q + {30'd0, res_o.num};
      end
      REQ_FLUSH: begin
        res_o.num               = 2'd1;
        res_o.res0.out_byte     = flush_sh[7:0];
        res_o.res0.bits_valid   = {1'b0, cnt_q};
        res_o.res0.run_end      = 1'b1;
        res_o.res0.is_final     = 1'b1;
        res_o.res0.total_bytes  = bytes_q + {31'd0, (cnt_q != 3'd0)};
        pend_d  = '0;
        cnt_d   = '0;
        bytes_d = '0;
      end
      REQ_LOAD, REQ_RSVD: begin
        res_o.num = 2'd0;
      end
      default: begin
        res_o.num = 2'd0;
      end
    endcase
  end

  // pending bits and stream byte count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= '0;
      cnt_q   <= '0;
      bytes_q <= '0;
    end else if (fire_i) begin
      pend_q  <= pend_d;
      cnt_q   <= cnt_d;
      bytes_q <= bytes_d;
    end
  end

endmodule

/* design/hcbp_out_fifo.sv */
module hcbp_out_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_en_i,
  input  hcbp_pkg::res_pair_t  wr_data_i,
  output logic                 room2_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output hcbp_pkg::out_t       out_data_o
);
  import hcbp_pkg::*;

  out_t mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] cnt_q;
  logic [1:0]            wr_num;
  logic                  rd;
  logic [FIFO_PTR_W-1:0] wr_ptr_p1;

  assign wr_num      = wr_en_i ? wr_data_i.num : 2'd0;
  assign rd          = out_valid_o && out_ready_i;
  assign wr_ptr_p1   = wr_ptr_q + FIFO_PTR_W'(1);
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign room2_o     = (cnt_q <= FIFO_CNT_W'(FIFO_DEPTH - 2));

  // storage, up to two entries written per transaction
  always_ff @(posedge clk_i) begin
    if (wr_num != 2'd0) begin
      mem_q[wr_ptr_q] <= wr_data_i.res0;
    end
    if (wr_num == 2'd2) begin
      mem_q[wr_ptr_p1] <= wr_data_i.res1;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(wr_num);
      if (rd) begin
        rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
      end
      cnt_q <= cnt_q + FIFO_CNT_W'(wr_num) - FIFO_CNT_W'(rd);
    end
  end

endmodule

/* design/huffman_code_bit_packer_top.sv */
// Huffman encoder back end: a 256-entry code table and an MSB-first bit packer.
// Load transactions write a symbol's code and length (length saturates at 16),
// encode transactions append the symbol's code and emit each completed byte,
// flush emits the left-aligned partial byte with its bit count and the stream's
// byte total, then restarts the stream while keeping the table. One item is
// accepted per cycle while stage one can pass its item on: the table is read
// at the accepting edge, and the merge and byte cut run while the item is held
// in stage one and write a four-entry output queue once it has room for two.
// The output port moves one byte per cycle while out_ready_i is high, so the
// bytes of an encode that completes two are offered one after the other; input
// ready drops only when stage one holds an item and the queue cannot take two.
module huffman_code_bit_packer_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  hcbp_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output hcbp_pkg::out_t  out_data_o
);
  import hcbp_pkg::*;

  logic                in_acc;
  logic                in_range;
  logic [LEN_W-1:0]    load_len;
  logic                s1_valid_q;
  logic [1:0]          s1_req_q;
  logic                s1_range_q;
  logic                s1_fire;
  logic                room2;
  logic [CODE_W-1:0]   tbl_code;
  logic [LEN_W-1:0]    tbl_len;
  logic [LEN_W-1:0]    enc_len;
  res_pair_t           res;

  // input transaction and symbol range check
  assign in_acc   = in_valid_i && in_ready_o;
  assign in_range = ({1'b0, in_data_i.symbol} < 9'(SYMBOL_COUNT));
  assign load_len = (in_data_i.code_length > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT)
                                                                : in_data_i.code_length;
  assign s1_fire    = s1_valid_q && room2;
  assign in_ready_o = !s1_valid_q || s1_fire;

  hcbp_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (in_acc && (in_data_i.req_type == REQ_LOAD) && in_range),
    .wr_idx_i  (in_data_i.symbol[SYM_W-1:0]),
    .wr_code_i (in_data_i.code_word),
    .wr_len_i  (load_len),
    .rd_en_i   (in_acc && (in_data_i.req_type == REQ_ENCODE)),
    .rd_idx_i  (in_data_i.symbol[SYM_W-1:0]),
    .rd_code_o (tbl_code),
    .rd_len_o  (tbl_len)
  );

  // stage one: request held beside the table read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_req_q   <= in_data_i.req_type;
      s1_range_q <= in_range;
    end
  end

  // out-of-range symbols encode as empty codes
  assign enc_len = s1_range_q ? tbl_len : '0;

  hcbp_packer u_packer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (s1_fire),
    .req_i  (s1_req_q),
    .code_i (tbl_code),
    .len_i  (enc_len),
    .res_o  (res)
  );

  hcbp_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (s1_fire),
    .wr_data_i   (res),
    .room2_o     (room2),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
